/* src/kmd_pkg.sv */
// ----------------------------------------------------------------------------
// kmd_pkg: keyboard matrix decoder shared definitions
// Matrix geometry, special key positions and the two key code tables.
// ----------------------------------------------------------------------------
package kmd_pkg;

  localparam int ROWS = 8;
  localparam int COLS = 10;
  localparam int KEYS = ROWS * COLS;

  localparam int ROW_W = $clog2(ROWS);
  localparam int IDX_W = 7;

  typedef logic [ROW_W-1:0] row_t;
  typedef logic [IDX_W-1:0] key_idx_t;
  typedef logic [COLS-1:0]  sense_t;
  typedef logic [7:0]       code_t;

  localparam row_t     LAST_ROW    = row_t'(ROWS - 1);
  localparam key_idx_t KEY_SHIFT_A = 7'd60;
  localparam key_idx_t KEY_SHIFT_B = 7'd66;
  localparam key_idx_t CTRL_POS    = 7'd20;
  localparam key_idx_t LOCK_POS    = 7'd40;
  localparam key_idx_t KEY_LIMIT   = key_idx_t'(KEYS);

  localparam code_t CTRL_MASK    = 8'h1F;
  localparam code_t CASE_BIT     = 8'h20;
  localparam code_t CHAR_LOWER_A = 8'h61;
  localparam code_t CHAR_LOWER_Z = 8'h7A;

  localparam code_t PLAIN_TAB [KEYS] = '{
    8'h31, 8'h33, 8'h35, 8'h37, 8'h39, 8'h2D, 8'h5C, 8'h0C, 8'h03, 8'h81,
    8'h1B, 8'h32, 8'h34, 8'h36, 8'h38, 8'h30, 8'h5E, 8'h05, 8'h08, 8'h85,
    8'h00, 8'h77, 8'h72, 8'h79, 8'h69, 8'h70, 8'h5B, 8'h0B, 8'h09, 8'h82,
    8'h71, 8'h65, 8'h74, 8'h75, 8'h6F, 8'h40, 8'h0A, 8'h08, 8'h7F, 8'h86,
    8'h00, 8'h73, 8'h66, 8'h68, 8'h6B, 8'h3B, 8'h5D, 8'h19, 8'h00, 8'h87,
    8'h61, 8'h64, 8'h67, 8'h6A, 8'h6C, 8'h3A, 8'h0D, 8'h1A, 8'h00, 8'h83,
    8'h00, 8'h78, 8'h76, 8'h6E, 8'h2C, 8'h2F, 8'h00, 8'h0A, 8'h00, 8'h88,
    8'h7A, 8'h63, 8'h62, 8'h6D, 8'h2E, 8'h5F, 8'h15, 8'h0C, 8'h20, 8'h84
  };

  localparam code_t SHIFT_TAB [KEYS] = '{
    8'h21, 8'h23, 8'h25, 8'h27, 8'h29, 8'h3D, 8'h7C, 8'h37, 8'h39, 8'h89,
    8'h1B, 8'h22, 8'h24, 8'h26, 8'h28, 8'h30, 8'h7E, 8'h38, 8'h08, 8'h8D,
    8'h00, 8'h57, 8'h52, 8'h59, 8'h49, 8'h50, 8'h7B, 8'h35, 8'h34, 8'h8A,
    8'h51, 8'h45, 8'h54, 8'h55, 8'h4F, 8'h60, 8'h0A, 8'h31, 8'h36, 8'h8E,
    8'h00, 8'h53, 8'h46, 8'h48, 8'h4B, 8'h2B, 8'h7D, 8'h33, 8'h00, 8'h8F,
    8'h41, 8'h44, 8'h47, 8'h4A, 8'h4C, 8'h2A, 8'h0D, 8'h32, 8'h00, 8'h8B,
    8'h00, 8'h58, 8'h56, 8'h4E, 8'h3C, 8'h3F, 8'h00, 8'h2E, 8'h00, 8'h90,
    8'h5A, 8'h43, 8'h42, 8'h4D, 8'h3E, 8'h5F, 8'h30, 8'h0D, 8'h20, 8'h8C
  };

endpackage

/* src/keyboard_matrix_decoder.sv */
// ----------------------------------------------------------------------------
// keyboard_matrix_decoder: key matrix scan to key code
// Collects one sense word per row, picks the first ordinary pressed key of a
// frame, reports its translated code after the last row if the key changed.
// ----------------------------------------------------------------------------
//   channel  handshake            payload
//   in       in_valid/in_ready    row_sense[9:0], rows 0..7 in order
//   out      out_valid/out_ready  key_code[7:0], key_valid, one item per frame
//
// One row item per cycle sustained unless a held result stalls a last row:
// an input register feeds the column priority encoder and table lookup,
// which load the result register.
// Synchronous active-high rst clears the frame state and the alpha lock.
// A held result stalls only the last row of the next frame; other rows flow.
module keyboard_matrix_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [9:0]  row_sense,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  key_code,
  output logic        key_valid
);

  // input register
  logic            s1_valid;
  kmd_pkg::sense_t s1_sense;

  // frame state
  kmd_pkg::row_t     row_count;
  logic              shift_seen;
  logic              ctrl_seen;
  logic              lock_seen;
  logic              press_found;
  kmd_pkg::key_idx_t press_index;
  logic              alpha_lock;
  logic              prev_lock;
  logic              last_valid;
  kmd_pkg::key_idx_t last_index;

  logic              frame_end;
  logic              s1_fire;
  kmd_pkg::key_idx_t row_base;
  logic              row_shift;
  logic              row_ctrl;
  logic              row_lock;
  logic              row_found;
  kmd_pkg::key_idx_t row_index;
  logic              shift_all;
  logic              ctrl_all;
  logic              lock_all;
  logic              found_all;
  kmd_pkg::key_idx_t index_all;
  logic              alpha_lock_next;
  logic              report;
  kmd_pkg::key_idx_t tab_index;
  kmd_pkg::code_t    raw_code;
  kmd_pkg::code_t    code_next;

  assign frame_end = (row_count == kmd_pkg::LAST_ROW);
  assign s1_fire   = s1_valid && (!frame_end || !out_valid || out_ready);
  assign in_ready  = !s1_valid || s1_fire;

  assign row_base = {1'b0, row_count, 3'b000} + {3'b000, row_count, 1'b0};

  always_comb begin
    kmd_pkg::key_idx_t idx;
    row_shift = 1'b0;
    row_ctrl  = 1'b0;
    row_lock  = 1'b0;
    row_found = 1'b0;
    row_index = '0;
    for (int col = 0; col < kmd_pkg::COLS; col++) begin
      idx = row_base + kmd_pkg::key_idx_t'(col);
      if (!s1_sense[col]) begin
        if (idx == kmd_pkg::KEY_SHIFT_A || idx == kmd_pkg::KEY_SHIFT_B) begin
          row_shift = 1'b1;
        end else if (idx == kmd_pkg::CTRL_POS) begin
          row_ctrl = 1'b1;
        end else if (idx == kmd_pkg::LOCK_POS) begin
          row_lock = 1'b1;
        end else if (!row_found) begin
          row_found = 1'b1;
          row_index = idx;
        end
      end
    end
  end

  assign shift_all = shift_seen | row_shift;
  assign ctrl_all  = ctrl_seen | row_ctrl;
  assign lock_all  = lock_seen | row_lock;
  assign found_all = press_found | row_found;
  assign index_all = press_found ? press_index : row_index;

  // lock toggles before the code of the same frame is translated
  assign alpha_lock_next = alpha_lock ^ (lock_all && !prev_lock);
  assign report = found_all && (!last_valid || index_all != last_index);
  assign tab_index = (index_all < kmd_pkg::KEY_LIMIT) ? index_all : '0;
  assign raw_code = shift_all ? kmd_pkg::SHIFT_TAB[tab_index]
                              : kmd_pkg::PLAIN_TAB[tab_index];

  always_comb begin
    code_next = '0;
    if (report) begin
      if (ctrl_all) begin
        code_next = raw_code & kmd_pkg::CTRL_MASK;
      end else if (alpha_lock_next && raw_code >= kmd_pkg::CHAR_LOWER_A
                   && raw_code <= kmd_pkg::CHAR_LOWER_Z) begin
        code_next = raw_code - kmd_pkg::CASE_BIT;
      end else begin
        code_next = raw_code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_sense <= row_sense;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count   <= '0;
      shift_seen  <= 1'b0;
      ctrl_seen   <= 1'b0;
      lock_seen   <= 1'b0;
      press_found <= 1'b0;
      press_index <= '0;
      alpha_lock  <= 1'b0;
      prev_lock   <= 1'b0;
      last_valid  <= 1'b0;
      last_index  <= '0;
    end else if (s1_fire) begin
      if (frame_end) begin
        row_count   <= '0;
        shift_seen  <= 1'b0;
        ctrl_seen   <= 1'b0;
        lock_seen   <= 1'b0;
        press_found <= 1'b0;
        press_index <= '0;
        alpha_lock  <= alpha_lock_next;
        prev_lock   <= lock_all;
        last_valid  <= found_all;
        last_index  <= found_all ? index_all : '0;
      end else begin
        row_count   <= row_count + 1'b1;
        shift_seen  <= shift_all;
        ctrl_seen   <= ctrl_all;
        lock_seen   <= lock_all;
        press_found <= found_all;
        press_index <= index_all;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && frame_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (s1_fire && frame_end) begin
      key_code  <= code_next;
      key_valid <= report;
    end
  end

endmodule

/* verif/key_report_checker.sv */
// ----------------------------------------------------------------------------
// key_report_checker: key report predictor and comparator
// Follows every accepted row item, rebuilds the frame state of the matrix
// scan, queues the key report due after each last row and compares every
// accepted report against the oldest one queued.
// ----------------------------------------------------------------------------
module key_report_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [9:0] row_sense,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] key_code,
  input  logic       key_valid,
  output int         fail_count,
  output int         pending
);

  typedef struct packed {
    kmd_pkg::code_t code;
    logic           valid;
  } key_report_t;

  localparam kmd_pkg::code_t UNSHIFTED_CODES [kmd_pkg::KEYS] = '{
    8'h31, 8'h33, 8'h35, 8'h37, 8'h39, 8'h2D, 8'h5C, 8'h0C, 8'h03, 8'h81,
    8'h1B, 8'h32, 8'h34, 8'h36, 8'h38, 8'h30, 8'h5E, 8'h05, 8'h08, 8'h85,
    8'h00, 8'h77, 8'h72, 8'h79, 8'h69, 8'h70, 8'h5B, 8'h0B, 8'h09, 8'h82,
    8'h71, 8'h65, 8'h74, 8'h75, 8'h6F, 8'h40, 8'h0A, 8'h08, 8'h7F, 8'h86,
    8'h00, 8'h73, 8'h66, 8'h68, 8'h6B, 8'h3B, 8'h5D, 8'h19, 8'h00, 8'h87,
    8'h61, 8'h64, 8'h67, 8'h6A, 8'h6C, 8'h3A, 8'h0D, 8'h1A, 8'h00, 8'h83,
    8'h00, 8'h78, 8'h76, 8'h6E, 8'h2C, 8'h2F, 8'h00, 8'h0A, 8'h00, 8'h88,
    8'h7A, 8'h63, 8'h62, 8'h6D, 8'h2E, 8'h5F, 8'h15, 8'h0C, 8'h20, 8'h84
  };

  localparam kmd_pkg::code_t SHIFTED_CODES [kmd_pkg::KEYS] = '{
    8'h21, 8'h23, 8'h25, 8'h27, 8'h29, 8'h3D, 8'h7C, 8'h37, 8'h39, 8'h89,
    8'h1B, 8'h22, 8'h24, 8'h26, 8'h28, 8'h30, 8'h7E, 8'h38, 8'h08, 8'h8D,
    8'h00, 8'h57, 8'h52, 8'h59, 8'h49, 8'h50, 8'h7B, 8'h35, 8'h34, 8'h8A,
    8'h51, 8'h45, 8'h54, 8'h55, 8'h4F, 8'h60, 8'h0A, 8'h31, 8'h36, 8'h8E,
    8'h00, 8'h53, 8'h46, 8'h48, 8'h4B, 8'h2B, 8'h7D, 8'h33, 8'h00, 8'h8F,
    8'h41, 8'h44, 8'h47, 8'h4A, 8'h4C, 8'h2A, 8'h0D, 8'h32, 8'h00, 8'h8B,
    8'h00, 8'h58, 8'h56, 8'h4E, 8'h3C, 8'h3F, 8'h00, 8'h2E, 8'h00, 8'h90,
    8'h5A, 8'h43, 8'h42, 8'h4D, 8'h3E, 8'h5F, 8'h30, 8'h0D, 8'h20, 8'h8C
  };

  // scan state of the frame in progress
  kmd_pkg::row_t     scan_row;
  logic              shift_held;
  logic              ctrl_held;
  logic              lock_held;
  logic              have_key;
  kmd_pkg::key_idx_t first_key;
  // state carried across frames
  logic              caps_on;
  logic              lock_prev;
  logic              prior_valid;
  kmd_pkg::key_idx_t prior_key;

  key_report_t expected_reports [$];

  task automatic clear_predictor();
    scan_row    = '0;
    shift_held  = 1'b0;
    ctrl_held   = 1'b0;
    lock_held   = 1'b0;
    have_key    = 1'b0;
    first_key   = '0;
    caps_on     = 1'b0;
    lock_prev   = 1'b0;
    prior_valid = 1'b0;
    prior_key   = '0;
  endtask

  task automatic scan_row_item(input kmd_pkg::sense_t sense);
    kmd_pkg::key_idx_t idx;
    key_report_t       report;
    for (int c = 0; c < kmd_pkg::COLS; c++) begin
      if (!sense[c]) begin
        idx = kmd_pkg::key_idx_t'(int'(scan_row) * kmd_pkg::COLS + c);
        if (idx == kmd_pkg::KEY_SHIFT_A || idx == kmd_pkg::KEY_SHIFT_B) begin
          shift_held = 1'b1;
        end else if (idx == kmd_pkg::CTRL_POS) begin
          ctrl_held = 1'b1;
        end else if (idx == kmd_pkg::LOCK_POS) begin
          lock_held = 1'b1;
        end else if (!have_key) begin
          have_key  = 1'b1;
          first_key = idx;
        end
      end
    end
    if (scan_row != kmd_pkg::LAST_ROW) begin
      scan_row = scan_row + 1'b1;
    end else begin
      // lock toggles before this frame's code is translated
      if (lock_held && !lock_prev) begin
        caps_on = !caps_on;
      end
      report = '0;
      if (have_key && (!prior_valid || first_key != prior_key)) begin
        report.valid = 1'b1;
        report.code  = shift_held ? SHIFTED_CODES[first_key]
                                  : UNSHIFTED_CODES[first_key];
        if (ctrl_held) begin
          report.code = report.code & kmd_pkg::CTRL_MASK;
        end else if (caps_on && report.code >= kmd_pkg::CHAR_LOWER_A
                     && report.code <= kmd_pkg::CHAR_LOWER_Z) begin
          report.code = report.code - kmd_pkg::CASE_BIT;
        end
      end
      expected_reports.push_back(report);
      prior_valid = have_key;
      prior_key   = have_key ? first_key : '0;
      lock_prev   = lock_held;
      scan_row    = '0;
      shift_held  = 1'b0;
      ctrl_held   = 1'b0;
      lock_held   = 1'b0;
      have_key    = 1'b0;
      first_key   = '0;
    end
  endtask

  always @(posedge clk) begin
    key_report_t want;
    if (rst) begin
      clear_predictor();
      expected_reports.delete();
      fail_count = 0;
    end else begin
      // compare first: a report can never belong to a row taken at this edge
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          $error("key report with none pending: key_code %h key_valid %b",
                 key_code, key_valid);
          fail_count++;
        end else begin
          want = expected_reports.pop_front();
          if (key_code !== want.code) begin
            $error("key_code: expected %h, got %h", want.code, key_code);
            fail_count++;
          end
          if (key_valid !== want.valid) begin
            $error("key_valid: expected %b, got %b", want.valid, key_valid);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        scan_row_item(row_sense);
      end
    end
    pending = expected_reports.size();
  end

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: keyboard matrix decoder testbench
// Feeds frames of eight row items, directed corner frames first and then
// random key patterns, with random gaps on both channels and one long output
// stall; the report checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int ITEM_TARGET = 550;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [9:0] row_sense;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] key_code;
  logic       key_valid;

  int fail_count;
  int pending;

  kmd_pkg::sense_t frame_rows [kmd_pkg::ROWS];
  int     held_key = -1;
  int     rows_sent = 0;
  logic   calm = 1'b0;
  logic   squeeze_req = 1'b0;
  logic   squeeze_done = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  keyboard_matrix_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .row_sense (row_sense),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .key_code  (key_code),
    .key_valid (key_valid)
  );

  key_report_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .row_sense  (row_sense),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .key_code   (key_code),
    .key_valid  (key_valid),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  task automatic press(input int idx);
    frame_rows[idx / kmd_pkg::COLS][idx % kmd_pkg::COLS] = 1'b0;
  endtask

  task automatic build_frame();
    int mode;
    int k;
    for (int r = 0; r < kmd_pkg::ROWS; r++) frame_rows[r] = '1;
    mode = $urandom_range(0, 99);
    if (mode < 10) begin
      // noise: any pattern at all
      for (int r = 0; r < kmd_pkg::ROWS; r++) frame_rows[r] = kmd_pkg::sense_t'($urandom);
      held_key = -1;
    end else begin
      if (mode < 35 && held_key >= 0) k = held_key;
      else if (mode < 45) k = -1;
      else k = $urandom_range(0, kmd_pkg::KEYS - 1);
      held_key = k;
      if (k >= 0) press(k);
      if ($urandom_range(0, 3) == 0) press($urandom_range(0, kmd_pkg::KEYS - 1));
      if ($urandom_range(0, 3) == 0) begin
        press($urandom_range(0, 1) ? kmd_pkg::KEY_SHIFT_A : kmd_pkg::KEY_SHIFT_B);
      end
      if ($urandom_range(0, 5) == 0) press(kmd_pkg::CTRL_POS);
      if ($urandom_range(0, 4) == 0) press(kmd_pkg::LOCK_POS);
    end
  endtask

  task automatic send_row(input kmd_pkg::sense_t v);
    int gap;
    gap = calm ? 0 : idle_len();
    if (gap > 0) begin
      in_valid  <= 1'b0;
      row_sense <= kmd_pkg::sense_t'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    row_sense <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    rows_sent++;
  endtask

  task automatic send_frame();
    for (int r = 0; r < kmd_pkg::ROWS; r++) send_row(frame_rows[r]);
  endtask

  initial begin
    int frame_no;
    rst       = 1'b1;
    in_valid  = 1'b0;
    row_sense = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // every key down: shift, ctrl and lock all at once, lock turns on
    for (int r = 0; r < kmd_pkg::ROWS; r++) frame_rows[r] = '0;
    send_frame();
    // nothing pressed
    for (int r = 0; r < kmd_pkg::ROWS; r++) frame_rows[r] = '1;
    send_frame();
    // a lone letter with alpha lock on
    for (int r = 0; r < kmd_pkg::ROWS; r++) frame_rows[r] = '1;
    press(50);
    send_frame();

    frame_no = 0;
    while (rows_sent < ITEM_TARGET) begin
      if (frame_no == 25) begin
        squeeze_req = 1'b1;
        calm = 1'b1;
      end else if (frame_no > 25 && $urandom_range(0, 7) == 0) begin
        calm = !calm;
      end
      build_frame();
      send_frame();
      frame_no++;
    end
    in_valid <= 1'b0;

    // let the checker take in the last row before looking at the count
    @(posedge clk);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (pending != 0) begin
      $error("%0d key reports never arrived", pending);
    end
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // output side: random ready, one long hold-off while rows keep coming
  initial begin
    int len;
    out_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (squeeze_req && !squeeze_done) begin
        out_ready <= 1'b0;
        for (int n = 0; n < 400; n++) @(posedge clk);
        squeeze_done = 1'b1;
      end else if (calm) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 2) != 0);
        len = idle_len() + 1;
        repeat (len) @(posedge clk);
      end
    end
  end

  initial begin
    #400000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
